// ===== rtl/ntprc_pkg.sv =====
// ----------------------------------------------------------------------------
// NTP reply checker package
// Field positions, check limits, time constants and status codes shared by
// the reply checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ntprc_pkg;

   // Byte positions of the captured fields inside a 48-byte reply.
   localparam logic [5:0] POS_STRATUM    = 6'd1;
   localparam logic [5:0] POS_REF_FIRST  = 6'd16;
   localparam logic [5:0] POS_REF_LAST   = 6'd19;
   localparam logic [5:0] POS_RXS_FIRST  = 6'd32;
   localparam logic [5:0] POS_RXS_LAST   = 6'd35;
   localparam logic [5:0] POS_TXS_FIRST  = 6'd40;
   localparam logic [5:0] POS_TXS_LAST   = 6'd43;
   localparam logic [5:0] POS_FRAC_FIRST = 6'd44;
   localparam logic [5:0] POS_FRAC_LAST  = 6'd47;

   localparam logic [5:0]  COUNT_MAX     = 6'd63;
   localparam logic [5:0]  REPLY_LEN     = 6'd48;
   localparam logic [7:0]  STRATUM_MIN   = 8'd1;
   localparam logic [7:0]  STRATUM_MAX   = 8'd15;

   // Seconds between the NTP era start (1900) and the Unix epoch (1970).
   localparam logic [31:0] UNIX_OFFSET   = 32'd2208988800;
   // Fraction units per millisecond, and the scale used for the estimate.
   localparam logic [22:0] FRAC_PER_MS   = 23'd4294967;
   localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
   localparam logic [9:0]  MS_MAX        = 10'd1000;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_LENGTH  = 3'd1,
      STATUS_BAD_STRATUM = 3'd2,
      STATUS_ZERO_REF    = 3'd3,
      STATUS_ZERO_RXS    = 3'd4,
      STATUS_RXS_LATE    = 3'd5
   } status_type;

endpackage : ntprc_pkg

`default_nettype wire

// ===== rtl/ntp_response_checker.sv =====
// A final byte passes through the input register, check stage, estimate
// stage and result register before its result appears on rsp_tvalid.
// Throughput: one byte per cycle unless results fill the three later stages;
// the four stages move independently; bytes flow while a result awaits rsp_tready.
// Reset: synchronous, active high; clears the byte count and all stage valids.
// ----------------------------------------------------------------------------
// NTP reply checker
// Parses one NTP reply arriving a byte per word, validates it on the final
// byte, and reports Unix seconds, milliseconds, round trip and the estimated
// moment of the whole second.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_response_checker
   import ntprc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // req_tdata: [7:0] data_byte, [39:8] sent_at_ms, [71:40] received_at_ms
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [71:0]   req_tdata,
   input  wire logic          req_tlast,
   // rsp_tdata: [2:0] status, [34:3] unix_seconds, [44:35] fraction_ms,
   //            [76:45] round_trip_ms, [108:77] second_mark_ms, [111:109] zero
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [111:0]       rsp_tdata
);

   // ---------------------------------------------------------------------
   // Stage enables. Each stage moves when it is empty or the stage after
   // it moves, so bubbles collapse and a stalled result does not block
   // bytes that produce no result.
   // ---------------------------------------------------------------------
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic en0, en1, en2, en3;

   assign en3 = !rsp_valid_ff || rsp_tready;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign en0 = !s0_valid_ff || en1;

   assign req_tready = en0;

   // ---------------------------------------------------------------------
   // Input register.
   // ---------------------------------------------------------------------
   logic [7:0]  s0_byte_ff;
   logic        s0_last_ff;
   logic [31:0] s0_sent_ff;
   logic [31:0] s0_recv_ff;

   always_ff @(posedge clock) begin
      if (en0) begin
         s0_byte_ff <= req_tdata[7:0];
         s0_last_ff <= req_tlast;
         s0_sent_ff <= req_tdata[39:8];
         s0_recv_ff <= req_tdata[71:40];
      end
   end

   // ---------------------------------------------------------------------
   // Reply state: the byte count and the captured big-endian fields. A byte
   // is consumed when it leaves the input register.
   // ---------------------------------------------------------------------
   logic        consume;
   logic [5:0]  count_ff, count_in, count_sat;
   logic [7:0]  stratum_ff, stratum_in;
   logic [31:0] ref_ff, ref_in;
   logic [31:0] rxs_ff, rxs_in;
   logic [31:0] txs_ff, txs_in;
   logic [31:0] frac_ff, frac_in;

   assign consume = s0_valid_ff && en1;

   always_comb begin
      count_sat  = (count_ff != COUNT_MAX) ? count_ff + 6'd1 : COUNT_MAX;
      count_in   = s0_last_ff ? 6'd0 : count_sat;
      stratum_in = stratum_ff;
      ref_in     = ref_ff;
      rxs_in     = rxs_ff;
      txs_in     = txs_ff;
      frac_in    = frac_ff;
      priority if (count_ff == POS_STRATUM) begin
         stratum_in = s0_byte_ff;
      end else if (count_ff >= POS_REF_FIRST && count_ff <= POS_REF_LAST) begin
         ref_in = {ref_ff[23:0], s0_byte_ff};
      end else if (count_ff >= POS_RXS_FIRST && count_ff <= POS_RXS_LAST) begin
         rxs_in = {rxs_ff[23:0], s0_byte_ff};
      end else if (count_ff >= POS_TXS_FIRST && count_ff <= POS_TXS_LAST) begin
         txs_in = {txs_ff[23:0], s0_byte_ff};
      end else if (count_ff >= POS_FRAC_FIRST && count_ff <= POS_FRAC_LAST) begin
         frac_in = {frac_ff[23:0], s0_byte_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 6'd0;
      end else if (consume) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consume) begin
         stratum_ff <= stratum_in;
         ref_ff     <= ref_in;
         rxs_ff     <= rxs_in;
         txs_ff     <= txs_in;
         frac_ff    <= frac_in;
      end
   end

   // ---------------------------------------------------------------------
   // Check stage. On the final byte the checks run on the captured fields.
   // A full-length reply ends on the last fraction byte, so the fraction is
   // taken with that byte shifted in; the other fields are already complete.
   // On a failed check the time fields are forced to zero here, which makes
   // every later stage produce zero as well.
   // ---------------------------------------------------------------------
   status_type  s1_status_in, s1_status_ff;
   logic [31:0] s1_unix_ff, s1_frac_ff, s1_rt_ff, s1_recv_ff;
   logic [31:0] frac_full;

   assign frac_full = {frac_ff[23:0], s0_byte_ff};

   always_comb begin
      priority if (count_sat != REPLY_LEN) begin
         s1_status_in = STATUS_BAD_LENGTH;
      end else if (stratum_ff < STRATUM_MIN || stratum_ff > STRATUM_MAX) begin
         s1_status_in = STATUS_BAD_STRATUM;
      end else if (ref_ff == 32'd0) begin
         s1_status_in = STATUS_ZERO_REF;
      end else if (rxs_ff == 32'd0) begin
         s1_status_in = STATUS_ZERO_RXS;
      end else if (rxs_ff > txs_ff) begin
         s1_status_in = STATUS_RXS_LATE;
      end else begin
         s1_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_status_ff <= s1_status_in;
         if (s1_status_in == STATUS_OK) begin
            s1_unix_ff <= txs_ff - UNIX_OFFSET;
            s1_frac_ff <= frac_full;
            s1_rt_ff   <= s0_recv_ff - s0_sent_ff;
            s1_recv_ff <= s0_recv_ff;
         end else begin
            s1_unix_ff <= 32'd0;
            s1_frac_ff <= 32'd0;
            s1_rt_ff   <= 32'd0;
            s1_recv_ff <= 32'd0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Estimate stage. FRAC_PER_MS, the fraction units per millisecond, is a hair under
   // 2^32/1000, so fraction*1000 >> 32 is the true quotient or one below.
   // The half round trip is taken off the received time in parallel.
   // ---------------------------------------------------------------------
   status_type  s2_status_ff;
   logic [31:0] s2_unix_ff, s2_frac_ff, s2_rt_ff, s2_base_ff;
   logic [9:0]  s2_est_ff;
   logic [41:0] scaled;

   assign scaled = {10'd0, s1_frac_ff} * {32'd0, MS_PER_SECOND};

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_status_ff <= s1_status_ff;
         s2_unix_ff   <= s1_unix_ff;
         s2_frac_ff   <= s1_frac_ff;
         s2_rt_ff     <= s1_rt_ff;
         s2_est_ff    <= scaled[41:32];
         s2_base_ff   <= s1_recv_ff - {1'b0, s1_rt_ff[31:1]};
      end
   end

   // ---------------------------------------------------------------------
   // Correction stage. The estimate is bumped by one when the fraction
   // reaches (estimate + 1) * FRAC_PER_MS units; both second-mark candidates are formed
   // side by side and the right one is selected.
   // ---------------------------------------------------------------------
   logic [9:0]  est_up;
   logic [32:0] up_prod;
   logic        take_up;
   logic [31:0] mark_lo, mark_hi;

   status_type  rsp_status_ff;
   logic [31:0] rsp_unix_ff, rsp_rt_ff, rsp_mark_ff;
   logic [9:0]  rsp_ms_ff;

   assign est_up  = s2_est_ff + 10'd1;
   assign up_prod = {23'd0, est_up} * {10'd0, FRAC_PER_MS};
   assign take_up = {1'b0, s2_frac_ff} >= up_prod;
   assign mark_lo = s2_base_ff - {22'd0, s2_est_ff};
   assign mark_hi = s2_base_ff - {22'd0, est_up};

   always_ff @(posedge clock) begin
      if (en3) begin
         rsp_status_ff <= s2_status_ff;
         rsp_unix_ff   <= s2_unix_ff;
         rsp_rt_ff     <= s2_rt_ff;
         rsp_ms_ff     <= take_up ? est_up : s2_est_ff;
         rsp_mark_ff   <= take_up ? mark_hi : mark_lo;
      end
   end

   // ---------------------------------------------------------------------
   // Stage valids. Only a final byte carries a result past the input
   // register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en0) begin
            s0_valid_ff <= req_tvalid;
         end
         if (en1) begin
            s1_valid_ff <= s0_valid_ff && s0_last_ff;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_mark_ff, rsp_rt_ff, rsp_ms_ff, rsp_unix_ff,
                        rsp_status_ff};

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
`ifndef SYNTHESIS
   a_fail_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |->
         rsp_unix_ff == 32'd0 && rsp_ms_ff == 10'd0 &&
         rsp_rt_ff == 32'd0 && rsp_mark_ff == 32'd0)
      else $error("failed reply carries nonzero time fields");

   a_ms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ms_ff <= MS_MAX)
      else $error("millisecond result above one second");

   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      consume && s0_last_ff |=> count_ff == 6'd0)
      else $error("byte count did not restart after the final byte");
`endif

endmodule : ntp_response_checker

`default_nettype wire
